FILE: design/quaternion_arithmetic_unit_top_defines.svh
// Assertion macros shared by the quaternion arithmetic unit checkers.
`ifndef QUATERNION_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// Concurrent assertion sampled on the rising clock edge, disabled during reset.
`define QAU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock edge, active during reset too.
`define QAU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/qau_pkg.sv
// Shared widths, operation codes and constants of the quaternion arithmetic unit.
package qau_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 29;
   localparam int OP_BITS   = 2;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int SUM_BITS  = 2 * WORD_BITS + 4;
   localparam int NUM_PROD  = 16;
   localparam int NUM_OUT   = 9;

   localparam int REQ_FIELD_BITS = OP_BITS + 8 * WORD_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = NUM_OUT * WORD_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [OP_BITS-1:0] OP_MUL    = 2'd0;
   localparam logic [OP_BITS-1:0] OP_ROTVEC = 2'd1;
   localparam logic [OP_BITS-1:0] OP_MATRIX = 2'd2;

   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   localparam logic signed [SUM_BITS-1:0] SUM_WORD_MAX =
      {{(SUM_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_WORD_MIN =
      {{(SUM_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

endpackage

FILE: design/qau_round_sat.sv
// Rounding shift and saturation of one accumulated result element.
module qau_round_sat
   import qau_pkg::*;
(
   input  logic signed [SUM_BITS-1:0]  acc,
   input  logic                        used,
   output logic        [WORD_BITS-1:0] res,
   output logic                        sat
);

   logic signed [SUM_BITS-1:0] shifted;
   logic                       over;
   logic                       under;

   always_comb begin
      shifted = acc >>> FRAC_BITS;
      over    = shifted > SUM_WORD_MAX;
      under   = shifted < SUM_WORD_MIN;
      if (!used) begin
         res = '0;
      end else if (over) begin
         res = WORD_MAX;
      end else if (under) begin
         res = WORD_MIN;
      end else begin
         res = shifted[WORD_BITS-1:0];
      end
      sat = used && (over || under);
   end

endmodule

FILE: design/quaternion_arithmetic_unit_top.sv
// Quaternion multiply, rotation vector and rotation matrix unit, top level.
// An item taken in passes through the product, sum, adjust and result registers before it can be sent.
// Throughput is one item per cycle while the output is not stalled, set by the sixteen registered 32x32 multipliers.
// Each stage holds its item while the stage after it is full and cannot move on, so a stall drops nothing.
// A synchronous active-high reset empties every stage; payload registers are not reset.
module quaternion_arithmetic_unit_top
   import qau_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // op, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, zero fill
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // r0, r1, r2, r3, r4, r5, r6, r7, r8
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // saturated
   output logic [0:0]               rsp_tuser
);

   localparam logic [1:0] MUL_IA [NUM_PROD] = '{
      2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3,
      2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3};
   localparam logic [1:0] MUL_IB [NUM_PROD] = '{
      2'd3, 2'd2, 2'd1, 2'd0, 2'd2, 2'd3, 2'd0, 2'd1,
      2'd1, 2'd0, 2'd3, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3};
   localparam logic [NUM_PROD-1:0] PROD_NEG  = 16'h7214;
   localparam logic [NUM_PROD-1:0] PROD_CONJ = 16'h7BDE;

   localparam logic [NUM_OUT-1:0] MASK_MUL     = 9'h00F;
   localparam logic [NUM_OUT-1:0] MASK_ROTVEC  = 9'h007;
   localparam logic [NUM_OUT-1:0] MASK_ALL     = 9'h1FF;
   localparam logic [NUM_OUT-1:0] MASK_OFFDIAG = 9'h0EE;

   localparam logic signed [SUM_BITS-1:0] HALF    = SUM_BITS'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [SUM_BITS-1:0] HALF_P1 = HALF + SUM_BITS'(1);

   function automatic logic signed [SUM_BITS-1:0] sterm(
      input logic signed [PROD_BITS-1:0] p,
      input logic                        neg
   );
      logic signed [SUM_BITS-1:0] e;
      e = {{(SUM_BITS-PROD_BITS){p[PROD_BITS-1]}}, p};
      return neg ? -e : e;
   endfunction

   logic en1, en2, en3, en4;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;

   logic signed [WORD_BITS-1:0] a_in [4];
   logic signed [WORD_BITS-1:0] b_in [4];
   logic        [OP_BITS-1:0]   op_in;
   logic signed [PROD_BITS-1:0] prod_in [NUM_PROD];
   logic signed [PROD_BITS-1:0] prod_ff [NUM_PROD];
   logic        [OP_BITS-1:0]   op1_ff;

   logic signed [SUM_BITS-1:0]  sum_in [NUM_OUT];
   logic signed [SUM_BITS-1:0]  sum_ff [NUM_OUT];
   logic        [OP_BITS-1:0]   op2_ff;
   logic                        conj;

   logic signed [SUM_BITS-1:0]  adj_in [NUM_OUT];
   logic signed [SUM_BITS-1:0]  adj_ff [NUM_OUT];
   logic        [NUM_OUT-1:0]   used_in;
   logic        [NUM_OUT-1:0]   used_ff;
   logic        [NUM_OUT-1:0]   dbl_mask;
   logic        [NUM_OUT-1:0]   neg_mask;
   logic signed [SUM_BITS-1:0]  dbl_val [NUM_OUT];

   logic        [WORD_BITS-1:0] res_in [NUM_OUT];
   logic        [NUM_OUT-1:0]   sat_vec;
   logic        [WORD_BITS-1:0] res_ff [NUM_OUT];
   logic                        sat_ff;

   assign en4 = !v4_ff || rsp_tready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   assign v1_in = en1 ? req_tvalid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;
   assign v4_in = en4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // Stage 1: sixteen signed products; the matrix op squares a against itself.
   always_comb begin
      op_in = req_tdata[OP_BITS-1:0];
      for (int k = 0; k < 4; k++) begin
         a_in[k] = req_tdata[OP_BITS + k * WORD_BITS +: WORD_BITS];
         b_in[k] = (op_in == OP_MATRIX) ? a_in[k]
                 : req_tdata[OP_BITS + (4 + k) * WORD_BITS +: WORD_BITS];
      end
      for (int m = 0; m < NUM_PROD; m++) begin
         prod_in[m] = PROD_BITS'(a_in[MUL_IA[m]]) * PROD_BITS'(b_in[MUL_IB[m]]);
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         op1_ff  <= op_in;
         prod_ff <= prod_in;
      end
   end

   // Stage 2: signed sums of the products for each result element.
   always_comb begin
      conj = (op1_ff == OP_ROTVEC);
      for (int k = 0; k < NUM_OUT; k++) begin
         sum_in[k] = '0;
      end
      unique case (op1_ff)
         OP_MUL, OP_ROTVEC: begin
            for (int k = 0; k < 4; k++) begin
               for (int j = 0; j < 4; j++) begin
                  sum_in[k] = sum_in[k] + sterm(prod_ff[4 * k + j],
                     PROD_NEG[4 * k + j] ^ (conj & PROD_CONJ[4 * k + j]));
               end
            end
         end
         OP_MATRIX: begin
            sum_in[0] = sterm(prod_ff[12], 1'b0) + sterm(prod_ff[13], 1'b1)
                      + sterm(prod_ff[14], 1'b1) + sterm(prod_ff[15], 1'b0);
            sum_in[1] = sterm(prod_ff[8], 1'b0) + sterm(prod_ff[10], 1'b0);
            sum_in[2] = sterm(prod_ff[4], 1'b0) + sterm(prod_ff[5], 1'b1);
            sum_in[3] = sterm(prod_ff[8], 1'b0) + sterm(prod_ff[10], 1'b1);
            sum_in[4] = sterm(prod_ff[12], 1'b1) + sterm(prod_ff[13], 1'b0)
                      + sterm(prod_ff[14], 1'b1) + sterm(prod_ff[15], 1'b0);
            sum_in[5] = sterm(prod_ff[1], 1'b0) + sterm(prod_ff[0], 1'b0);
            sum_in[6] = sterm(prod_ff[4], 1'b0) + sterm(prod_ff[5], 1'b0);
            sum_in[7] = sterm(prod_ff[1], 1'b0) + sterm(prod_ff[0], 1'b1);
            sum_in[8] = sterm(prod_ff[12], 1'b1) + sterm(prod_ff[13], 1'b1)
                      + sterm(prod_ff[14], 1'b0) + sterm(prod_ff[15], 1'b0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         op2_ff <= op1_ff;
         sum_ff <= sum_in;
      end
   end

   // Stage 3: sign rule, doubling and the rounding offset folded into one add.
   always_comb begin
      unique case (op2_ff)
         OP_MUL: begin
            used_in  = MASK_MUL;
            dbl_mask = '0;
            neg_mask = sum_ff[3][SUM_BITS-1] ? MASK_MUL : '0;
         end
         OP_ROTVEC: begin
            used_in  = MASK_ROTVEC;
            dbl_mask = MASK_ROTVEC;
            neg_mask = sum_ff[3][SUM_BITS-1] ? MASK_MUL : '0;
         end
         OP_MATRIX: begin
            used_in  = MASK_ALL;
            dbl_mask = MASK_OFFDIAG;
            neg_mask = '0;
         end
         default: begin
            used_in  = '0;
            dbl_mask = '0;
            neg_mask = '0;
         end
      endcase
      for (int k = 0; k < NUM_OUT; k++) begin
         dbl_val[k] = dbl_mask[k] ? (sum_ff[k] <<< 1) : sum_ff[k];
         adj_in[k]  = neg_mask[k] ? (~dbl_val[k] + HALF_P1) : (dbl_val[k] + HALF);
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         used_ff <= used_in;
         adj_ff  <= adj_in;
      end
   end

   // Stage 4: rounding shift and clamp into the output register.
   for (genvar k = 0; k < NUM_OUT; k++) begin : g_round
      qau_round_sat u_round (
         .acc  (adj_ff[k]),
         .used (used_ff[k]),
         .res  (res_in[k]),
         .sat  (sat_vec[k])
      );
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         res_ff <= res_in;
         sat_ff <= |sat_vec;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tuser  = sat_ff;

   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < NUM_OUT; k++) begin
         rsp_tdata[k * WORD_BITS +: WORD_BITS] = res_ff[k];
      end
   end

endmodule

FILE: design/qau_checker.sv
// Port-level assertions for the quaternion arithmetic unit and their binding.
`include "quaternion_arithmetic_unit_top_defines.svh"

module qau_checker
   import qau_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [0:0]               rsp_tuser
);

   logic [NUM_OUT-1:0]     at_limit;
   logic                   req_take;
   logic                   rsp_stall;
   logic [RSP_DATA_BITS:0] rsp_bus;

   assign req_take  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_bus   = {rsp_tuser, rsp_tdata};

   always_comb begin
      for (int k = 0; k < NUM_OUT; k++) begin
         at_limit[k] = (rsp_tdata[k * WORD_BITS +: WORD_BITS] == WORD_MAX)
                    || (rsp_tdata[k * WORD_BITS +: WORD_BITS] == WORD_MIN);
      end
   end

   `QAU_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_tvalid, "result valid after reset")
   `QAU_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_bus), "stalled item changed")
   `QAU_ASSERT(a_latency, req_take ##1 rsp_tready [*3] |=> rsp_tvalid, "item lost in the pipe")
   `QAU_ASSERT(a_sat_limit, rsp_tvalid && rsp_tuser[0] |-> |at_limit, "flag set, none clamped")

endmodule

bind quaternion_arithmetic_unit_top qau_checker u_qau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: dv/tb_quaternion_arithmetic_unit_top.sv
// Self-checking testbench for the quaternion arithmetic unit stream interface.
module tb_quaternion_arithmetic_unit_top
   import qau_pkg::*;
();

   localparam logic [OP_BITS-1:0] OP_UNDEFINED = 2'd3;
   localparam int QX = 0;
   localparam int QY = 1;
   localparam int QZ = 2;
   localparam int QW = 3;
   localparam int DIRECTED_ITEMS_MAX = 25;
   localparam int PHASE_ITEMS = 375;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int SETTLE_CYCLES = 20;
   localparam int MAX_PRINTED = 100;

   localparam logic [WORD_BITS-1:0] Q_ONE      = 32'h2000_0000;
   localparam logic [WORD_BITS-1:0] Q_NEG_ONE  = 32'hE000_0000;
   localparam logic [WORD_BITS-1:0] Q_HALF_LSB = 32'h1000_0000;
   localparam logic [WORD_BITS-1:0] Q_LSB      = 32'h0000_0001;
   localparam logic [WORD_BITS-1:0] Q_NEG_LSB  = 32'hFFFF_FFFF;
   localparam logic [WORD_BITS-1:0] Q_ZERO     = '0;

   typedef logic signed [79:0] wide_type;

   typedef struct packed {
      logic [3:0][WORD_BITS-1:0] b;
      logic [3:0][WORD_BITS-1:0] a;
      logic [OP_BITS-1:0]        op;
   } quat_req_type;

   typedef struct packed {
      logic [NUM_OUT-1:0][WORD_BITS-1:0] r;
      logic                              sat;
   } quat_rsp_type;

   class quat_result_checker;
      quat_rsp_type pending_results[$];
      int           mismatches;
      int           results_checked;
      int           saturated_results;
      int           op_counts[4];

      function logic [WORD_BITS-1:0] to_word(wide_type v, inout bit sat);
         wide_type q;
         wide_type top;
         wide_type bottom;
         top    = (wide_type'(1) <<< (WORD_BITS - 1)) - 1;
         bottom = -(wide_type'(1) <<< (WORD_BITS - 1));
         q = (v + (wide_type'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         if (q > top) begin
            sat = 1'b1;
            return WORD_MAX;
         end
         if (q < bottom) begin
            sat = 1'b1;
            return WORD_MIN;
         end
         return q[WORD_BITS-1:0];
      endfunction

      function quat_rsp_type quat_math(quat_req_type rq);
         wide_type     a[4];
         wide_type     b[4];
         wide_type     p[4];
         wide_type     m[NUM_OUT];
         quat_rsp_type res;
         bit           sat;
         sat = 1'b0;
         res = '0;
         for (int k = 0; k < 4; k++) begin
            a[k] = $signed(rq.a[k]);
            b[k] = $signed(rq.b[k]);
         end
         case (rq.op)
            OP_MUL, OP_ROTVEC: begin
               if (rq.op == OP_ROTVEC) begin
                  for (int k = QX; k <= QZ; k++) b[k] = -b[k];
               end
               p[QX] =  a[QX]*b[QW] + a[QY]*b[QZ] - a[QZ]*b[QY] + a[QW]*b[QX];
               p[QY] = -a[QX]*b[QZ] + a[QY]*b[QW] + a[QZ]*b[QX] + a[QW]*b[QY];
               p[QZ] =  a[QX]*b[QY] - a[QY]*b[QX] + a[QZ]*b[QW] + a[QW]*b[QZ];
               p[QW] = -a[QX]*b[QX] - a[QY]*b[QY] - a[QZ]*b[QZ] + a[QW]*b[QW];
               // A quaternion and its negation describe the same rotation.
               if (p[QW] < 0) begin
                  for (int k = 0; k < 4; k++) p[k] = -p[k];
               end
               if (rq.op == OP_MUL) begin
                  for (int k = 0; k < 4; k++) res.r[k] = to_word(p[k], sat);
               end else begin
                  for (int k = QX; k <= QZ; k++) res.r[k] = to_word(p[k] + p[k], sat);
               end
            end
            OP_MATRIX: begin
               m[0] =  a[QX]*a[QX] - a[QY]*a[QY] - a[QZ]*a[QZ] + a[QW]*a[QW];
               m[1] = 2 * (a[QX]*a[QY] + a[QZ]*a[QW]);
               m[2] = 2 * (a[QX]*a[QZ] - a[QY]*a[QW]);
               m[3] = 2 * (a[QX]*a[QY] - a[QZ]*a[QW]);
               m[4] = -a[QX]*a[QX] + a[QY]*a[QY] - a[QZ]*a[QZ] + a[QW]*a[QW];
               m[5] = 2 * (a[QY]*a[QZ] + a[QX]*a[QW]);
               m[6] = 2 * (a[QX]*a[QZ] + a[QY]*a[QW]);
               m[7] = 2 * (a[QY]*a[QZ] - a[QX]*a[QW]);
               m[8] = -a[QX]*a[QX] - a[QY]*a[QY] + a[QZ]*a[QZ] + a[QW]*a[QW];
               for (int k = 0; k < NUM_OUT; k++) res.r[k] = to_word(m[k], sat);
            end
            default: begin
            end
         endcase
         res.sat = sat;
         return res;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= MAX_PRINTED) $display("MISMATCH: %s", msg);
      endtask

      function void note_request(quat_req_type rq);
         op_counts[rq.op]++;
         pending_results.push_back(quat_math(rq));
      endfunction

      task check_response(quat_rsp_type got);
         quat_rsp_type want;
         if (pending_results.size() == 0) begin
            report_mismatch("result arrived with no item outstanding");
            return;
         end
         want = pending_results.pop_front();
         results_checked++;
         if (got.sat === 1'b1) saturated_results++;
         for (int k = 0; k < NUM_OUT; k++) begin
            if (got.r[k] !== want.r[k]) begin
               report_mismatch($sformatf("result %0d r%0d: got %h, expected %h",
                                         results_checked, k, got.r[k], want.r[k]));
            end
         end
         if (got.sat !== want.sat) begin
            report_mismatch($sformatf("result %0d saturated: got %b, expected %b",
                                      results_checked, got.sat, want.sat));
         end
      endtask

      task flush_leftovers();
         while (pending_results.size() != 0) begin
            void'(pending_results.pop_front());
            report_mismatch("expected result never arrived");
         end
      endtask

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [0:0]               rsp_tuser;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_off_cycles = 0;

   quat_result_checker results = new();

   quaternion_arithmetic_unit_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   initial begin
      quat_req_type seen;
      quat_rsp_type got;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (req_tvalid === 1'b1 && req_tready === 1'b1) begin
               seen = req_tdata[REQ_FIELD_BITS-1:0];
               results.note_request(seen);
            end
            if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
               got.r = rsp_tdata[RSP_FIELD_BITS-1:0];
               got.sat = rsp_tuser[0];
               results.check_response(got);
            end
         end
      end
   end

   function automatic logic [3:0][WORD_BITS-1:0] quat(logic [WORD_BITS-1:0] x,
                                                     logic [WORD_BITS-1:0] y,
                                                     logic [WORD_BITS-1:0] z,
                                                     logic [WORD_BITS-1:0] w);
      return {w, z, y, x};
   endfunction

   function automatic quat_req_type make_item(logic [OP_BITS-1:0] op,
                                              logic [3:0][WORD_BITS-1:0] a,
                                              logic [3:0][WORD_BITS-1:0] b);
      quat_req_type rq;
      rq.op = op;
      rq.a = a;
      rq.b = b;
      return rq;
   endfunction

   function automatic logic [WORD_BITS-1:0] rand_component();
      int unsigned pick;
      int          v;
      pick = $urandom_range(99);
      if (pick < 45) begin
         v = int'($urandom_range(32'h4000_0000)) - int'(Q_ONE);
      end else if (pick < 75) begin
         v = $urandom();
      end else if (pick < 90) begin
         v = $urandom();
         v = v >>> $urandom_range(12);
      end else begin
         case ($urandom_range(4))
            0: v = WORD_MIN;
            1: v = WORD_MAX;
            2: v = Q_ZERO;
            3: v = Q_NEG_LSB;
            default: v = Q_ONE;
         endcase
      end
      return v;
   endfunction

   function automatic quat_req_type rand_item();
      quat_req_type rq;
      int unsigned  pick;
      pick = $urandom_range(15);
      if (pick == 15) begin
         rq.op = OP_UNDEFINED;
      end else begin
         case (pick % 3)
            0: rq.op = OP_MUL;
            1: rq.op = OP_ROTVEC;
            default: rq.op = OP_MATRIX;
         endcase
      end
      for (int k = 0; k < 4; k++) begin
         rq.a[k] = rand_component();
         rq.b[k] = rand_component();
      end
      return rq;
   endfunction

   task drive_item(quat_req_type rq);
      int gap;
      gap = 0;
      while (gap < 50 && $urandom_range(99) < sender_idle_pct) gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_BITS'(rq);
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   task end_burst();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task wait_for_drain();
      while (results.outstanding() != 0) @(posedge clock);
   endtask

   task run_directed();
      quat_req_type        items[$];
      logic [OP_BITS-1:0]  op;
      logic [3:0][31:0]    all_min;
      logic [3:0][31:0]    all_max;
      logic [3:0][31:0]    identity;
      all_min  = {4{WORD_MIN}};
      all_max  = {4{WORD_MAX}};
      identity = quat(Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE);
      for (int k = 0; k < 4; k++) begin
         case (k)
            0: op = OP_MUL;
            1: op = OP_ROTVEC;
            2: op = OP_MATRIX;
            default: op = OP_UNDEFINED;
         endcase
         items.push_back(make_item(op, all_min, all_min));
         items.push_back(make_item(op, all_max, all_max));
         items.push_back(make_item(op, all_max, all_min));
         items.push_back(make_item(op, '0, '0));
      end
      items.push_back(make_item(OP_MUL, identity, identity));
      items.push_back(make_item(OP_ROTVEC, identity, identity));
      items.push_back(make_item(OP_MATRIX, identity, '0));
      // A negative scalar part flips the whole product.
      items.push_back(make_item(OP_MUL, quat(Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG_ONE), identity));
      items.push_back(make_item(OP_ROTVEC, quat(Q_HALF_LSB, Q_ZERO, Q_ZERO, Q_NEG_ONE),
                                identity));
      // Exact half-way values round toward plus infinity.
      items.push_back(make_item(OP_MUL, quat(Q_LSB, Q_ZERO, Q_ZERO, Q_ZERO),
                                quat(Q_ZERO, Q_ZERO, Q_ZERO, Q_HALF_LSB)));
      items.push_back(make_item(OP_MUL, quat(Q_NEG_LSB, Q_ZERO, Q_ZERO, Q_ZERO),
                                quat(Q_ZERO, Q_ZERO, Q_ZERO, Q_HALF_LSB)));
      items.push_back(make_item(OP_MUL, quat(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX),
                                quat(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN)));
      while (items.size() > DIRECTED_ITEMS_MAX) void'(items.pop_back());
      foreach (items[i]) drive_item(items[i]);
      end_burst();
      wait_for_drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
               // Hold off the output long enough for the pipeline to back up.
               hold_off_cycles = HOLD_OFF_CYCLES;
            end
            1: begin
               sender_idle_pct = 61;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 61;
            end
            default: begin
               sender_idle_pct = 30;
               receiver_stall_pct = 30;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) drive_item(rand_item());
         end_burst();
         wait_for_drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      results.flush_leftovers();

      $display("Checked %0d results: %0d mul, %0d rotvec, %0d matrix, %0d bad op.",
               results.results_checked, results.op_counts[OP_MUL],
               results.op_counts[OP_ROTVEC], results.op_counts[OP_MATRIX],
               results.op_counts[OP_UNDEFINED]);
      $display("%0d clamped results, %0d mismatches, four flow-control mixes.",
               results.saturated_results, results.mismatches);
      if (results.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
